// ===== sv/pnp_pkg.sv =====
// Package of shared constants, types and arithmetic helpers for the polyline nearest-point block.
`timescale 1ns / 1ps
`default_nettype none
package pnp_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 30;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int DOT_W      = SQ_W + 1;
   localparam int MUL_W      = 2 * DIFF_W + 2;
   localparam int QUO_W      = DIFF_W;
   localparam int NUM_W      = SQ_W + QUO_W - 1;
   localparam int DIST_W     = 61;
   localparam int INTP_W     = COORD_BITS + 2;
   localparam int WORD_W     = 3 * COORD_BITS + 1;
   localparam int QCNT_W     = $clog2(QUO_W + 1);

   localparam logic [DIST_W-1:0] BEST_LIMIT = DIST_W'(64'h7fffffff << 20);

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [4:0] OP_CLEAR    = 5'd1;
   localparam logic [4:0] OP_APPEND   = 5'd2;
   localparam logic [4:0] OP_QINIT    = 5'd3;
   localparam logic [4:0] OP_RD_NEXT  = 5'd4;
   localparam logic [4:0] OP_LAT_P1   = 5'd5;
   localparam logic [4:0] OP_LAT_P0   = 5'd6;
   localparam logic [4:0] OP_DIFF     = 5'd7;
   localparam logic [4:0] OP_L1       = 5'd8;
   localparam logic [4:0] OP_L2       = 5'd9;
   localparam logic [4:0] OP_D1       = 5'd10;
   localparam logic [4:0] OP_D2       = 5'd11;
   localparam logic [4:0] OP_IMLO     = 5'd12;
   localparam logic [4:0] OP_IMHI     = 5'd13;
   localparam logic [4:0] OP_IDIV     = 5'd14;
   localparam logic [4:0] OP_IFIN     = 5'd15;
   localparam logic [4:0] OP_DSQ1     = 5'd16;
   localparam logic [4:0] OP_DSQ2     = 5'd17;
   localparam logic [4:0] OP_SUPD     = 5'd18;
   localparam logic [4:0] OP_IDX_VTX  = 5'd19;
   localparam logic [4:0] OP_IDX_DEC  = 5'd20;
   localparam logic [4:0] OP_VSQ1     = 5'd21;
   localparam logic [4:0] OP_VSQ2     = 5'd22;
   localparam logic [4:0] OP_VCMP     = 5'd23;
   localparam logic [4:0] OP_RD_BIDX  = 5'd24;
   localparam logic [4:0] OP_RD_BNEXT = 5'd25;
   localparam logic [4:0] OP_SPLIT    = 5'd26;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] axis;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_lt2;
      logic idx_zero;
      logic seg_skip;
      logic better;
      logic div_busy;
   } dp_status_type;

   function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_BITS-1:0] a,
                                                       input logic signed [COORD_BITS-1:0] b);
      return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
   endfunction

   function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] a);
      return a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
   endfunction

endpackage
`default_nettype wire

// ===== sv/pnp_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module pnp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/pnp_div.sv =====
// Iterative restoring divider giving one quotient bit per cycle for the interpolation.
`timescale 1ns / 1ps
`default_nettype none
module pnp_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pnp_pkg::NUM_W-1:0]  num,
   input  wire logic [pnp_pkg::SQ_W-1:0]   den,
   output logic                            busy,
   output logic      [pnp_pkg::QUO_W-1:0]  quo,
   output logic                            rem_nz
);

   logic                         busy_ff;
   logic [pnp_pkg::QCNT_W-1:0]   cnt_ff;
   logic [pnp_pkg::SQ_W-1:0]     rem_ff;
   logic [pnp_pkg::SQ_W-1:0]     rem_in;
   logic [pnp_pkg::QUO_W-1:0]    low_ff;
   logic [pnp_pkg::QUO_W-1:0]    quo_ff;
   logic [pnp_pkg::SQ_W:0]       trial;
   logic [pnp_pkg::SQ_W:0]       diff;
   logic                         qbit;

   always_comb begin
      trial  = {rem_ff, low_ff[pnp_pkg::QUO_W-1]};
      diff   = trial - {1'b0, den};
      qbit   = trial >= {1'b0, den};
      rem_in = qbit ? diff[pnp_pkg::SQ_W-1:0] : trial[pnp_pkg::SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= pnp_pkg::QCNT_W'(pnp_pkg::QUO_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == pnp_pkg::QCNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num[pnp_pkg::NUM_W-1:pnp_pkg::QUO_W]};
         low_ff <= num[pnp_pkg::QUO_W-1:0];
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[pnp_pkg::QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[pnp_pkg::QUO_W-2:0], qbit};
      end
   end

   assign busy   = busy_ff;
   assign quo    = quo_ff;
   assign rem_nz = rem_ff != '0;

endmodule
`default_nettype wire

// ===== sv/pnp_dp.sv =====
// Datapath: point store, shared multiplier, divider and best-candidate registers.
`timescale 1ns / 1ps
`default_nettype none
module pnp_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pnp_pkg::ctrl_cmd_type                cmd,
   input  wire logic signed [pnp_pkg::COORD_BITS-1:0] req_x_coord,
   input  wire logic signed [pnp_pkg::COORD_BITS-1:0] req_y_coord,
   input  wire logic signed [pnp_pkg::COORD_BITS-1:0] req_z_coord,
   input  wire logic                                 req_part_start,
   output pnp_pkg::dp_status_type                    status,
   output logic                                      rsp_found,
   output logic signed [pnp_pkg::COORD_BITS-1:0]     rsp_nearest_x,
   output logic signed [pnp_pkg::COORD_BITS-1:0]     rsp_nearest_y,
   output logic signed [pnp_pkg::COORD_BITS-1:0]     rsp_nearest_z,
   output logic        [pnp_pkg::DIST_W-1:0]         rsp_distance_sq,
   output logic        [pnp_pkg::ADDR_W-1:0]         rsp_nearest_index,
   output logic                                      rsp_on_vertex,
   output logic                                      rsp_splittable
);

   localparam int CB = pnp_pkg::COORD_BITS;

   logic [pnp_pkg::CNT_W-1:0]    count_ff;
   logic [pnp_pkg::ADDR_W-1:0]   idx_ff;
   logic signed [CB-1:0]         qx_ff, qy_ff;
   logic signed [CB-1:0]         p0x_ff, p0y_ff, p0z_ff, p1x_ff, p1y_ff, p1z_ff;
   logic                         p1part_ff, m0_ff;
   logic signed [pnp_pkg::DIFF_W-1:0] ex_ff, ey_ff, ez_ff, wx_ff, wy_ff;
   logic [pnp_pkg::SQ_W-1:0]     len2_ff;
   logic signed [pnp_pkg::DOT_W-1:0] dot_ff;
   logic [pnp_pkg::NUM_W-1:0]    wide_ff;
   logic signed [CB-1:0]         nx_ff, ny_ff, nz_ff;
   logic [pnp_pkg::DIST_W-1:0]   dd_ff, best_ff;
   logic signed [CB-1:0]         bx_ff, by_ff, bz_ff;
   logic [pnp_pkg::ADDR_W-1:0]   bidx_ff;
   logic                         bvert_ff, found_ff, split_ff;

   logic                         wr_en;
   logic [pnp_pkg::ADDR_W-1:0]   rd_addr;
   logic [pnp_pkg::WORD_W-1:0]   rd_data;
   logic signed [CB-1:0]         rd_x, rd_y, rd_z;
   logic                         rd_part;

   logic signed [pnp_pkg::DIFF_W:0] mul_a, mul_b;
   logic signed [pnp_pkg::MUL_W-1:0] mul_p;
   logic signed [pnp_pkg::DIFF_W-1:0] sq_d, delta_sel;
   logic signed [CB-1:0]         base_sel;
   logic [pnp_pkg::DIFF_W-1:0]   mag_sel;
   logic                         div_busy, rem_nz;
   logic [pnp_pkg::QUO_W-1:0]    quo;
   logic signed [pnp_pkg::INTP_W-1:0] qe, fv, iv;
   logic signed [CB-1:0]         interp;

   assign {rd_part, rd_z, rd_y, rd_x} = rd_data;
   assign wr_en = (cmd.op == pnp_pkg::OP_APPEND) &&
                  (count_ff < pnp_pkg::CNT_W'(pnp_pkg::MAX_POINTS));

   always_comb begin
      unique case (cmd.op)
         pnp_pkg::OP_RD_NEXT:  rd_addr = idx_ff + 1'b1;
         pnp_pkg::OP_RD_BIDX:  rd_addr = bidx_ff;
         pnp_pkg::OP_RD_BNEXT: rd_addr = bidx_ff + 1'b1;
         default:              rd_addr = idx_ff;
      endcase
   end

   pnp_ram #(.WIDTH(pnp_pkg::WORD_W), .DEPTH(pnp_pkg::MAX_POINTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[pnp_pkg::ADDR_W-1:0]),
      .wr_data ({req_part_start, req_z_coord, req_y_coord, req_x_coord}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.axis)
         pnp_pkg::AX_Y: begin
            delta_sel = ey_ff;
            base_sel  = p0y_ff;
         end
         pnp_pkg::AX_Z: begin
            delta_sel = ez_ff;
            base_sel  = p0z_ff;
         end
         default: begin
            delta_sel = ex_ff;
            base_sel  = p0x_ff;
         end
      endcase
      mag_sel = pnp_pkg::mag(delta_sel);
   end

   always_comb begin
      case (cmd.op)
         pnp_pkg::OP_DSQ1: sq_d = pnp_pkg::sdiff(qx_ff, nx_ff);
         pnp_pkg::OP_DSQ2: sq_d = pnp_pkg::sdiff(qy_ff, ny_ff);
         pnp_pkg::OP_VSQ1: sq_d = pnp_pkg::sdiff(qx_ff, p0x_ff);
         default:          sq_d = pnp_pkg::sdiff(qy_ff, p0y_ff);
      endcase
      case (cmd.op)
         pnp_pkg::OP_L1: begin
            mul_a = {ex_ff[pnp_pkg::DIFF_W-1], ex_ff};
            mul_b = {ex_ff[pnp_pkg::DIFF_W-1], ex_ff};
         end
         pnp_pkg::OP_L2: begin
            mul_a = {ey_ff[pnp_pkg::DIFF_W-1], ey_ff};
            mul_b = {ey_ff[pnp_pkg::DIFF_W-1], ey_ff};
         end
         pnp_pkg::OP_D1: begin
            mul_a = {wx_ff[pnp_pkg::DIFF_W-1], wx_ff};
            mul_b = {ex_ff[pnp_pkg::DIFF_W-1], ex_ff};
         end
         pnp_pkg::OP_D2: begin
            mul_a = {wy_ff[pnp_pkg::DIFF_W-1], wy_ff};
            mul_b = {ey_ff[pnp_pkg::DIFF_W-1], ey_ff};
         end
         pnp_pkg::OP_IMLO: begin
            mul_a = {1'b0, mag_sel};
            mul_b = {1'b0, dot_ff[pnp_pkg::QUO_W-1:0]};
         end
         pnp_pkg::OP_IMHI: begin
            mul_a = {1'b0, mag_sel};
            mul_b = {1'b0, dot_ff[pnp_pkg::SQ_W-1:pnp_pkg::QUO_W]};
         end
         default: begin
            mul_a = {sq_d[pnp_pkg::DIFF_W-1], sq_d};
            mul_b = {sq_d[pnp_pkg::DIFF_W-1], sq_d};
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   pnp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.op == pnp_pkg::OP_IDIV),
      .num    (wide_ff),
      .den    (len2_ff),
      .busy   (div_busy),
      .quo    (quo),
      .rem_nz (rem_nz)
   );

   // Truncation toward zero of base + delta * dot / len2.
   always_comb begin
      qe = $signed({1'b0, quo});
      fv = delta_sel[pnp_pkg::DIFF_W-1] ? -qe - $signed(pnp_pkg::INTP_W'(rem_nz)) : qe;
      iv = $signed({{2{base_sel[CB-1]}}, base_sel}) + fv;
      if (rem_nz && iv[pnp_pkg::INTP_W-1]) begin
         iv = iv + pnp_pkg::INTP_W'(1);
      end
      interp = iv[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.op == pnp_pkg::OP_CLEAR) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         pnp_pkg::OP_QINIT: begin
            qx_ff    <= req_x_coord;
            qy_ff    <= req_y_coord;
            best_ff  <= pnp_pkg::BEST_LIMIT;
            bx_ff    <= '0;
            by_ff    <= '0;
            bz_ff    <= '0;
            bidx_ff  <= '0;
            bvert_ff <= 1'b0;
            split_ff <= 1'b1;
            found_ff <= count_ff != '0;
            idx_ff   <= (count_ff >= pnp_pkg::CNT_W'(2)) ?
                        pnp_pkg::ADDR_W'(count_ff - pnp_pkg::CNT_W'(2)) : '0;
         end
         pnp_pkg::OP_LAT_P1: begin
            p1x_ff    <= rd_x;
            p1y_ff    <= rd_y;
            p1z_ff    <= rd_z;
            p1part_ff <= rd_part;
         end
         pnp_pkg::OP_LAT_P0: begin
            p0x_ff <= rd_x;
            p0y_ff <= rd_y;
            p0z_ff <= rd_z;
         end
         pnp_pkg::OP_DIFF: begin
            ex_ff <= pnp_pkg::sdiff(p1x_ff, p0x_ff);
            ey_ff <= pnp_pkg::sdiff(p1y_ff, p0y_ff);
            ez_ff <= pnp_pkg::sdiff(p1z_ff, p0z_ff);
            wx_ff <= pnp_pkg::sdiff(qx_ff, p0x_ff);
            wy_ff <= pnp_pkg::sdiff(qy_ff, p0y_ff);
         end
         pnp_pkg::OP_L1:   len2_ff <= mul_p[pnp_pkg::SQ_W-1:0];
         pnp_pkg::OP_L2:   len2_ff <= len2_ff + mul_p[pnp_pkg::SQ_W-1:0];
         pnp_pkg::OP_D1:   dot_ff  <= mul_p[pnp_pkg::DOT_W-1:0];
         pnp_pkg::OP_D2:   dot_ff  <= dot_ff + mul_p[pnp_pkg::DOT_W-1:0];
         pnp_pkg::OP_IMLO: wide_ff <= pnp_pkg::NUM_W'(mul_p[pnp_pkg::SQ_W-1:0]);
         pnp_pkg::OP_IMHI: begin
            wide_ff <= wide_ff + {mul_p[pnp_pkg::SQ_W-2:0], {pnp_pkg::QUO_W{1'b0}}};
         end
         pnp_pkg::OP_IFIN: begin
            case (cmd.axis)
               pnp_pkg::AX_Y: ny_ff <= interp;
               pnp_pkg::AX_Z: nz_ff <= interp;
               default:       nx_ff <= interp;
            endcase
         end
         pnp_pkg::OP_DSQ1, pnp_pkg::OP_VSQ1: dd_ff <= mul_p[pnp_pkg::DIST_W-1:0];
         pnp_pkg::OP_DSQ2, pnp_pkg::OP_VSQ2: dd_ff <= dd_ff + mul_p[pnp_pkg::DIST_W-1:0];
         pnp_pkg::OP_SUPD: begin
            best_ff  <= dd_ff;
            bx_ff    <= nx_ff;
            by_ff    <= ny_ff;
            bz_ff    <= nz_ff;
            bidx_ff  <= idx_ff;
            bvert_ff <= 1'b0;
         end
         pnp_pkg::OP_VCMP: begin
            if (dd_ff < best_ff) begin
               best_ff  <= dd_ff;
               bx_ff    <= p0x_ff;
               by_ff    <= p0y_ff;
               bz_ff    <= p0z_ff;
               bidx_ff  <= idx_ff;
               bvert_ff <= 1'b1;
            end
         end
         pnp_pkg::OP_IDX_VTX: idx_ff <= pnp_pkg::ADDR_W'(count_ff - 1'b1);
         pnp_pkg::OP_IDX_DEC: idx_ff <= idx_ff - 1'b1;
         pnp_pkg::OP_RD_BNEXT: m0_ff <= rd_part;
         pnp_pkg::OP_SPLIT: begin
            if (bvert_ff && (bidx_ff == '0 || ({1'b0, bidx_ff} + 1'b1) == count_ff ||
                             m0_ff || rd_part)) begin
               split_ff <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.count_zero = count_ff == '0;
      status.count_lt2  = count_ff < pnp_pkg::CNT_W'(2);
      status.idx_zero   = idx_ff == '0;
      status.seg_skip   = p1part_ff || len2_ff == '0 || dot_ff < 0 ||
                          dot_ff > $signed({1'b0, len2_ff});
      status.better     = dd_ff < best_ff;
      status.div_busy   = div_busy;
   end

   assign rsp_found         = found_ff;
   assign rsp_nearest_x     = found_ff ? bx_ff : '0;
   assign rsp_nearest_y     = found_ff ? by_ff : '0;
   assign rsp_nearest_z     = found_ff ? bz_ff : '0;
   assign rsp_distance_sq   = found_ff ? best_ff : '0;
   assign rsp_nearest_index = found_ff ? bidx_ff : '0;
   assign rsp_on_vertex     = found_ff && bvert_ff;
   assign rsp_splittable    = found_ff && split_ff;

endmodule
`default_nettype wire

// ===== sv/pnp_ctrl.sv =====
// Controller state machine that sequences the datapath through commands and queries.
`timescale 1ns / 1ps
`default_nettype none
module pnp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [1:0]             req_command,
   input  wire pnp_pkg::dp_status_type status,
   output pnp_pkg::ctrl_cmd_type       cmd,
   output logic                        busy,
   output logic                        rsp_valid
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_SRD1  = 5'd1;
   localparam logic [4:0] S_SRD0  = 5'd2;
   localparam logic [4:0] S_SLAT  = 5'd3;
   localparam logic [4:0] S_SDIFF = 5'd4;
   localparam logic [4:0] S_SL1   = 5'd5;
   localparam logic [4:0] S_SL2   = 5'd6;
   localparam logic [4:0] S_SD1   = 5'd7;
   localparam logic [4:0] S_SD2   = 5'd8;
   localparam logic [4:0] S_SCHK  = 5'd9;
   localparam logic [4:0] S_ILO   = 5'd10;
   localparam logic [4:0] S_IHI   = 5'd11;
   localparam logic [4:0] S_IDIV  = 5'd12;
   localparam logic [4:0] S_IWAIT = 5'd13;
   localparam logic [4:0] S_IFIN  = 5'd14;
   localparam logic [4:0] S_DSQ1  = 5'd15;
   localparam logic [4:0] S_DSQ2  = 5'd16;
   localparam logic [4:0] S_SCMP  = 5'd17;
   localparam logic [4:0] S_SUPD  = 5'd18;
   localparam logic [4:0] S_SNEXT = 5'd19;
   localparam logic [4:0] S_VRD   = 5'd20;
   localparam logic [4:0] S_VLAT  = 5'd21;
   localparam logic [4:0] S_V1    = 5'd22;
   localparam logic [4:0] S_V2    = 5'd23;
   localparam logic [4:0] S_VCMP  = 5'd24;
   localparam logic [4:0] S_VNEXT = 5'd25;
   localparam logic [4:0] S_FRD0  = 5'd26;
   localparam logic [4:0] S_FRD1  = 5'd27;
   localparam logic [4:0] S_FSPL  = 5'd28;
   localparam logic [4:0] S_OUT   = 5'd29;

   logic [4:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd.op   = pnp_pkg::OP_NONE;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_command)
                  pnp_pkg::CMD_CLEAR:  cmd.op = pnp_pkg::OP_CLEAR;
                  pnp_pkg::CMD_APPEND: cmd.op = pnp_pkg::OP_APPEND;
                  pnp_pkg::CMD_QUERY: begin
                     cmd.op = pnp_pkg::OP_QINIT;
                     if (status.count_zero) begin
                        state_in = S_OUT;
                     end else if (status.count_lt2) begin
                        state_in = S_VRD;
                     end else begin
                        state_in = S_SRD1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SRD1: begin
            cmd.op   = pnp_pkg::OP_RD_NEXT;
            state_in = S_SRD0;
         end
         S_SRD0: begin
            cmd.op   = pnp_pkg::OP_LAT_P1;
            state_in = S_SLAT;
         end
         S_SLAT: begin
            cmd.op   = pnp_pkg::OP_LAT_P0;
            state_in = S_SDIFF;
         end
         S_SDIFF: begin
            cmd.op   = pnp_pkg::OP_DIFF;
            state_in = S_SL1;
         end
         S_SL1: begin
            cmd.op   = pnp_pkg::OP_L1;
            state_in = S_SL2;
         end
         S_SL2: begin
            cmd.op   = pnp_pkg::OP_L2;
            state_in = S_SD1;
         end
         S_SD1: begin
            cmd.op   = pnp_pkg::OP_D1;
            state_in = S_SD2;
         end
         S_SD2: begin
            cmd.op   = pnp_pkg::OP_D2;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            axis_in  = pnp_pkg::AX_X;
            state_in = status.seg_skip ? S_SNEXT : S_ILO;
         end
         S_ILO: begin
            cmd.op   = pnp_pkg::OP_IMLO;
            state_in = S_IHI;
         end
         S_IHI: begin
            cmd.op   = pnp_pkg::OP_IMHI;
            state_in = S_IDIV;
         end
         S_IDIV: begin
            cmd.op   = pnp_pkg::OP_IDIV;
            state_in = S_IWAIT;
         end
         S_IWAIT: begin
            if (!status.div_busy) begin
               state_in = S_IFIN;
            end
         end
         S_IFIN: begin
            cmd.op = pnp_pkg::OP_IFIN;
            case (axis_ff)
               pnp_pkg::AX_X: begin
                  axis_in  = pnp_pkg::AX_Y;
                  state_in = S_ILO;
               end
               pnp_pkg::AX_Y: state_in = S_DSQ1;
               default:       state_in = S_SUPD;
            endcase
         end
         S_DSQ1: begin
            cmd.op   = pnp_pkg::OP_DSQ1;
            state_in = S_DSQ2;
         end
         S_DSQ2: begin
            cmd.op   = pnp_pkg::OP_DSQ2;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (status.better) begin
               axis_in  = pnp_pkg::AX_Z;
               state_in = S_ILO;
            end else begin
               state_in = S_SNEXT;
            end
         end
         S_SUPD: begin
            cmd.op   = pnp_pkg::OP_SUPD;
            state_in = S_SNEXT;
         end
         S_SNEXT: begin
            if (status.idx_zero) begin
               cmd.op   = pnp_pkg::OP_IDX_VTX;
               state_in = S_VRD;
            end else begin
               cmd.op   = pnp_pkg::OP_IDX_DEC;
               state_in = S_SRD1;
            end
         end
         S_VRD:  state_in = S_VLAT;
         S_VLAT: begin
            cmd.op   = pnp_pkg::OP_LAT_P0;
            state_in = S_V1;
         end
         S_V1: begin
            cmd.op   = pnp_pkg::OP_VSQ1;
            state_in = S_V2;
         end
         S_V2: begin
            cmd.op   = pnp_pkg::OP_VSQ2;
            state_in = S_VCMP;
         end
         S_VCMP: begin
            cmd.op   = pnp_pkg::OP_VCMP;
            state_in = S_VNEXT;
         end
         S_VNEXT: begin
            if (status.idx_zero) begin
               state_in = S_FRD0;
            end else begin
               cmd.op   = pnp_pkg::OP_IDX_DEC;
               state_in = S_VRD;
            end
         end
         S_FRD0: begin
            cmd.op   = pnp_pkg::OP_RD_BIDX;
            state_in = S_FRD1;
         end
         S_FRD1: begin
            cmd.op   = pnp_pkg::OP_RD_BNEXT;
            state_in = S_FSPL;
         end
         S_FSPL: begin
            cmd.op   = pnp_pkg::OP_SPLIT;
            state_in = S_OUT;
         end
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= pnp_pkg::AX_X;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

endmodule
`default_nettype wire

// ===== sv/polyline_nearest_point_top.sv =====
// Top level of the polyline nearest-point block: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
// Clear and append items give no result. A query walks every stored segment from the highest
// start index down, then every vertex, on one shared multiplier and a one-bit-per-cycle divider,
// and ends with the split check and the result. A segment that is skipped or whose foot misses
// it is not interpolated; one whose foot lands on it is interpolated on x and y, and on z as
// well if it wins, each interpolation waiting on the divider. An empty store answers in the
// cycle after the item. The result is shown on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, and the receiver cannot stall it; busy stays high until then.
module polyline_nearest_point_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [1:0]                            req_command,
   input  wire logic signed [pnp_pkg::COORD_BITS-1:0] req_x_coord,
   input  wire logic signed [pnp_pkg::COORD_BITS-1:0] req_y_coord,
   input  wire logic signed [pnp_pkg::COORD_BITS-1:0] req_z_coord,
   input  wire logic                                  req_part_start,
   output logic                                       rsp_valid,
   output logic                                       rsp_found,
   output logic signed [pnp_pkg::COORD_BITS-1:0]      rsp_nearest_x,
   output logic signed [pnp_pkg::COORD_BITS-1:0]      rsp_nearest_y,
   output logic signed [pnp_pkg::COORD_BITS-1:0]      rsp_nearest_z,
   output logic        [pnp_pkg::DIST_W-1:0]          rsp_distance_sq,
   output logic        [pnp_pkg::ADDR_W-1:0]          rsp_nearest_index,
   output logic                                       rsp_on_vertex,
   output logic                                       rsp_splittable
);

   pnp_pkg::ctrl_cmd_type  cmd;
   pnp_pkg::dp_status_type status;

   pnp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   pnp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_x_coord       (req_x_coord),
      .req_y_coord       (req_y_coord),
      .req_z_coord       (req_z_coord),
      .req_part_start    (req_part_start),
      .status            (status),
      .rsp_found         (rsp_found),
      .rsp_nearest_x     (rsp_nearest_x),
      .rsp_nearest_y     (rsp_nearest_y),
      .rsp_nearest_z     (rsp_nearest_z),
      .rsp_distance_sq   (rsp_distance_sq),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_on_vertex     (rsp_on_vertex),
      .rsp_splittable    (rsp_splittable)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result shown while idle");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   assert property (@(posedge clock) disable iff (reset)
                    (start && !busy && req_command == pnp_pkg::CMD_QUERY) |=> busy)
      else $error("query item not taken up");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_found) |-> (rsp_distance_sq == '0 && !rsp_on_vertex))
      else $error("empty-store result carries data");
`endif

endmodule
`default_nettype wire
